[rtl/pba_pkg.sv]
// types and constants shared by the page bitmap allocator
`default_nettype none

package pba_pkg;

  localparam int FIELD_W  = 9;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;
  localparam int ROW_BITS = 8;
  localparam int BIT_W    = 3;

  localparam logic [OP_W-1:0] OP_CLEAR   = 2'd0;
  localparam logic [OP_W-1:0] OP_ALLOC   = 2'd1;
  localparam logic [OP_W-1:0] OP_RELEASE = 2'd2;
  localparam logic [OP_W-1:0] OP_MARK    = 2'd3;

  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD_PAGE = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [FIELD_W-1:0] page;
  } pba_req_t;

  typedef struct packed {
    logic [FIELD_W-1:0]  granted_page;
    logic [STATUS_W-1:0] status;
    logic [FIELD_W-1:0]  free_pages;
  } pba_rsp_t;

endpackage

`default_nettype wire

[rtl/pba_row_find.sv]
// lowest free page search within one row of the used map
`default_nettype none

module pba_row_find (
  input  logic [pba_pkg::ROW_BITS-1:0] row_i,
  input  logic [pba_pkg::ROW_BITS-1:0] avail_i,
  output logic                         found_o,
  output logic [pba_pkg::BIT_W-1:0]    bit_o,
  output logic [pba_pkg::ROW_BITS-1:0] row_set_o
);
  import pba_pkg::*;

  logic [ROW_BITS-1:0] free_bits;

  assign free_bits = ~row_i & avail_i;
  assign found_o   = |free_bits;

  // walk from the top so the lowest free bit wins
  always_comb begin
    bit_o = '0;
    for (int b = ROW_BITS - 1; b >= 0; b--) begin
      if (free_bits[b]) begin
        bit_o = BIT_W'(b);
      end
    end
  end

  always_comb begin
    row_set_o        = row_i;
    row_set_o[bit_o] = 1'b1;
  end

endmodule

`default_nettype wire

[rtl/page_bitmap_allocator.sv]
// first-fit page allocator over a used/free bitmap of flash pages
`default_nettype none

// One request at a time: a transaction is taken when start is high and busy
// is low, and its single result appears on result_o for exactly one cycle
// with done_o high; the receiver cannot stall it, so it must sample on that
// cycle. The used map lives in a memory of ROWS = ceil(PAGES/8) rows of
// eight bits with one write and one registered read port, and that port
// sets the timing: allocate scans one row per cycle (32 rows at 256
// pages) and answers without a scan when no page is free; clear writes
// every row; release and mark-used do a read-modify-write; a page number
// out of range is answered straight from idle. After reset the block
// sweeps the memory to zero with busy high before taking its first
// transaction. Page numbers are 1-based; free_pages is the count after
// the request.
module page_bitmap_allocator #(
  parameter int PAGES = 256
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               start,
  output logic              busy,
  input  pba_pkg::pba_req_t req_i,
  output logic              done_o,
  output pba_pkg::pba_rsp_t result_o
);
  import pba_pkg::*;

  localparam int ROWS  = (PAGES + ROW_BITS - 1) / ROW_BITS;
  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CNT_W = $clog2(PAGES + 1);
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

  // sequencer states
  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_CLEAR   = 3'd1;
  localparam logic [2:0] ST_SCAN    = 3'd2;
  localparam logic [2:0] ST_RMW_RD  = 3'd3;
  localparam logic [2:0] ST_RMW_CHK = 3'd4;

  logic [2:0]       state_q, state_d;
  logic [ROW_W-1:0] clr_q, clr_d;        // clearing sweep row
  logic             clr_rsp_q, clr_rsp_d; // sweep answers a clear request
  logic [ROW_W-1:0] scan_q, scan_d;      // next row to read in a scan
  logic             issue_q, issue_d;    // scan still has rows to read
  logic             rvld_q, rvld_d;      // read data of a scan row is valid
  logic [ROW_W-1:0] rrow_q, rrow_d;      // row whose data is in rd_data_q
  logic [CNT_W-1:0] cnt_q, cnt_d;        // free page count
  pba_req_t         req_q, req_d;
  logic             done_q, done_d;
  pba_rsp_t         rsp_q, rsp_d;

  // used map: one bit per page, set means used
  logic [ROW_BITS-1:0] map_mem [ROWS];
  logic [ROW_BITS-1:0] rd_data_q;
  logic [ROW_W-1:0]    rd_addr;
  logic                wr_en;
  logic [ROW_W-1:0]    wr_addr;
  logic [ROW_BITS-1:0] wr_data;

  // page number decode for release and mark-used
  logic [ROW_W+2:0]    req_idx;
  logic [ROW_W-1:0]    req_row;
  logic [BIT_W-1:0]    req_bit;
  logic                req_bad;

  // row search
  logic [ROW_BITS-1:0] avail;
  logic                find_hit;
  logic [BIT_W-1:0]    find_bit;
  logic [ROW_BITS-1:0] find_row;

  assign req_idx = (ROW_W+3)'(32'(req_q.page) - 32'd1);
  assign req_row = req_idx[ROW_W+2:3];
  assign req_bit = req_idx[2:0];
  assign req_bad = (req_i.page == '0) || (32'(req_i.page) > 32'(PAGES));

  // bits past the last page in the final row count as used
  always_comb begin
    for (int b = 0; b < ROW_BITS; b++) begin
      avail[b] = ((32'(rrow_q) * 32'(ROW_BITS) + 32'(b)) < 32'(PAGES));
    end
  end

  pba_row_find u_row_find (
    .row_i     (rd_data_q),
    .avail_i   (avail),
    .found_o   (find_hit),
    .bit_o     (find_bit),
    .row_set_o (find_row)
  );

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    clr_rsp_d = clr_rsp_q;
    scan_d    = scan_q;
    issue_d   = issue_q;
    rvld_d    = 1'b0;
    rrow_d    = rrow_q;
    cnt_d     = cnt_q;
    req_d     = req_q;
    done_d    = 1'b0;
    rsp_d     = rsp_q;
    wr_en     = 1'b0;
    wr_addr   = clr_q;
    wr_data   = '0;
    rd_addr   = scan_q;

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          req_d = req_i;
          unique case (req_i.op) inside
            OP_CLEAR: begin
              clr_d     = '0;
              clr_rsp_d = 1'b1;
              state_d   = ST_CLEAR;
            end
            OP_ALLOC: begin
              if (cnt_q == '0) begin
                // nothing free, no need to scan
                done_d             = 1'b1;
                rsp_d.granted_page = '0;
                rsp_d.status       = STATUS_FULL;
                rsp_d.free_pages   = FIELD_W'(cnt_q);
              end else begin
                scan_d  = '0;
                issue_d = 1'b1;
                state_d = ST_SCAN;
              end
            end
            OP_RELEASE, OP_MARK: begin
              if (req_bad) begin
                done_d             = 1'b1;
                rsp_d.granted_page = '0;
                rsp_d.status       = STATUS_BAD_PAGE;
                rsp_d.free_pages   = FIELD_W'(cnt_q);
              end else begin
                state_d = ST_RMW_RD;
              end
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end

      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_q;
        wr_data = '0;
        if (clr_q == LAST_ROW) begin
          cnt_d   = CNT_W'(PAGES);
          state_d = ST_IDLE;
          if (clr_rsp_q) begin
            done_d             = 1'b1;
            rsp_d.granted_page = '0;
            rsp_d.status       = STATUS_OK;
            rsp_d.free_pages   = FIELD_W'(PAGES);
          end
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end

      ST_SCAN: begin
        // read one row per cycle, test the row read the cycle before
        rd_addr = scan_q;
        if (issue_q) begin
          rvld_d = 1'b1;
          rrow_d = scan_q;
          if (scan_q == LAST_ROW) begin
            issue_d = 1'b0;
          end else begin
            scan_d = scan_q + 1'b1;
          end
        end
        if (rvld_q) begin
          if (find_hit) begin
            wr_en   = 1'b1;
            wr_addr = rrow_q;
            wr_data = find_row;
            if (cnt_q != '0) begin
              cnt_d = cnt_q - 1'b1;
            end
            done_d             = 1'b1;
            rsp_d.granted_page = FIELD_W'(32'(rrow_q) * 32'(ROW_BITS)
                                          + 32'(find_bit) + 32'd1);
            rsp_d.status       = STATUS_OK;
            rsp_d.free_pages   = FIELD_W'(cnt_d);
            issue_d            = 1'b0;
            rvld_d             = 1'b0;
            state_d            = ST_IDLE;
          end else if (!issue_q) begin
            done_d             = 1'b1;
            rsp_d.granted_page = '0;
            rsp_d.status       = STATUS_FULL;
            rsp_d.free_pages   = FIELD_W'(cnt_q);
            state_d            = ST_IDLE;
          end
        end
      end

      ST_RMW_RD: begin
        rd_addr = req_row;
        state_d = ST_RMW_CHK;
      end

      ST_RMW_CHK: begin
        wr_addr = req_row;
        if (req_q.op == OP_RELEASE) begin
          if (rd_data_q[req_bit]) begin
            wr_en            = 1'b1;
            wr_data          = rd_data_q;
            wr_data[req_bit] = 1'b0;
            cnt_d            = cnt_q + 1'b1;
          end
        end else if (!rd_data_q[req_bit]) begin
          wr_en            = 1'b1;
          wr_data          = rd_data_q;
          wr_data[req_bit] = 1'b1;
          if (cnt_q != '0) begin
            cnt_d = cnt_q - 1'b1;
          end
        end
        done_d             = 1'b1;
        rsp_d.granted_page = '0;
        rsp_d.status       = STATUS_OK;
        rsp_d.free_pages   = FIELD_W'(cnt_d);
        state_d            = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // map memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      map_mem[wr_addr] <= wr_data;
    end
    rd_data_q <= map_mem[rd_addr];
  end

  // control state; reset starts the clearing sweep with no result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      clr_rsp_q <= 1'b0;
      scan_q    <= '0;
      issue_q   <= 1'b0;
      rvld_q    <= 1'b0;
      cnt_q     <= CNT_W'(PAGES);
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      clr_rsp_q <= clr_rsp_d;
      scan_q    <= scan_d;
      issue_q   <= issue_d;
      rvld_q    <= rvld_d;
      cnt_q     <= cnt_d;
      done_q    <= done_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    rsp_q  <= rsp_d;
    rrow_q <= rrow_d;
  end

  assign busy     = (state_q != ST_IDLE);
  assign done_o   = done_q;
  assign result_o = rsp_q;

endmodule

`default_nettype wire
